[hw/rtl/lkvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared sizes and controller/datapath interface types for the LRU key-value
// cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int CAPACITY   = 16;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;
	localparam int CFG_W      = 5;
	localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RANK_W     = IDX_W;
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	localparam int LIM_W      = (CNT_W > CFG_W) ? CNT_W : CFG_W;
	localparam int IN_DATA_W  = KEY_BITS + VALUE_BITS;

	localparam logic [CFG_W-1:0] CAP_RESET = CFG_W'(16);

	typedef struct packed {
		logic capture;
		logic lookup;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} status_t;

endpackage

[hw/rtl/lru_key_value_cache_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// result: registered at the commit step, after the capture and lookup steps
// one transaction in flight at a time (capture, lookup, commit sequence)
// a stalled output holds the commit step until the result register is free
// reset: all entries invalid, ranks and occupancy zero, capacity 16
module lru_key_value_cache_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [lkvc_pkg::IN_DATA_W-1:0]   s_tdata,  // lookup_key, value_in
	input  logic [0:0]                       s_tuser,  // mode
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lkvc_pkg::VALUE_BITS-1:0]  m_tdata,  // value_out
	output logic [0:0]                       m_tuser,  // found
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [lkvc_pkg::CFG_W-1:0]       cfg_data
);
	import lkvc_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	lkvc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	lkvc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item is in flight");

	a_result_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |-> ##3 m_tvalid)
		else $error("result not presented after commit");

	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tdata == '1))
		else $error("miss result carries a value other than -1");

endmodule

[hw/rtl/lkvc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ctrl
// Sequencer: captures a transaction, runs the lookup, then commits the update
// and the result once the output register is free.
// ----------------------------------------------------------------------------
module lkvc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  lkvc_pkg::status_t status,
	output lkvc_pkg::cmd_t    cmd
);
	import lkvc_pkg::*;

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOOKUP = 2'd1;
	localparam logic [1:0] ST_COMMIT = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (status.out_free) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[hw/rtl/lkvc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_datapath
// Entry store, parallel key match, recency ranks, victim and free slot
// selection, capacity register and result register.
// ----------------------------------------------------------------------------
module lkvc_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lkvc_pkg::cmd_t                   cmd,
	output lkvc_pkg::status_t                status,
	input  logic [lkvc_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic [0:0]                       s_tuser,
	input  logic                             cfg_valid,
	input  logic [lkvc_pkg::CFG_W-1:0]       cfg_data,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [lkvc_pkg::VALUE_BITS-1:0]  m_tdata,
	output logic [0:0]                       m_tuser
);
	import lkvc_pkg::*;

	logic [KEY_BITS-1:0]   key_q   [CAPACITY];
	logic [VALUE_BITS-1:0] value_q [CAPACITY];
	logic [RANK_W-1:0]     rank_q  [CAPACITY];
	logic [CAPACITY-1:0]   valid_q;
	logic [CNT_W-1:0]      used_q;
	logic [CFG_W-1:0]      cap_q;

	logic                  mode_q;
	logic [KEY_BITS-1:0]   in_key_q;
	logic [VALUE_BITS-1:0] in_value_q;

	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [RANK_W-1:0]     hit_rank_q;
	logic [IDX_W-1:0]      victim_idx_q;
	logic [IDX_W-1:0]      free_idx_q;
	logic                  full_q;

	logic                  hit_c;
	logic [IDX_W-1:0]      hit_idx_c;
	logic [RANK_W-1:0]     hit_rank_c;
	logic [IDX_W-1:0]      victim_idx_c;
	logic [IDX_W-1:0]      free_idx_c;
	logic                  free_seen;
	logic [RANK_W-1:0]     last_rank;
	logic [LIM_W-1:0]      cap_ext;
	logic [LIM_W-1:0]      limit;
	logic                  full_c;

	logic                  touch;
	logic                  insert;
	logic                  wr_key;
	logic                  wr_value;
	logic [IDX_W-1:0]      slot;
	logic [RANK_W-1:0]     thr;

	logic                  out_valid_q;
	logic                  out_found_q;
	logic [VALUE_BITS-1:0] out_value_q;

	assign last_rank = RANK_W'(used_q - CNT_W'(1));

	// clamp the configured limit into 1..CAPACITY
	always_comb begin
		cap_ext = LIM_W'(cap_q);
		if (cap_ext == '0) begin
			limit = LIM_W'(1);
		end else if (cap_ext > LIM_W'(CAPACITY)) begin
			limit = LIM_W'(CAPACITY);
		end else begin
			limit = cap_ext;
		end
		full_c = (LIM_W'(used_q) >= limit);
	end

	always_comb begin
		hit_c        = 1'b0;
		hit_idx_c    = '0;
		hit_rank_c   = '0;
		victim_idx_c = '0;
		free_idx_c   = '0;
		free_seen    = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (valid_q[i] && (key_q[i] == in_key_q)) begin
				hit_c      = 1'b1;
				hit_idx_c  = IDX_W'(i);
				hit_rank_c = rank_q[i];
			end
			if (valid_q[i] && (rank_q[i] == last_rank)) begin
				victim_idx_c = IDX_W'(i);
			end
			if (!valid_q[i] && !free_seen) begin
				free_idx_c = IDX_W'(i);
				free_seen  = 1'b1;
			end
		end
	end

	always_comb begin
		slot     = hit_q ? hit_idx_q : (full_q ? victim_idx_q : free_idx_q);
		thr      = hit_q ? hit_rank_q : last_rank;
		touch    = cmd.commit && (hit_q || mode_q);
		insert   = cmd.commit && mode_q && !hit_q && !full_q;
		wr_value = cmd.commit && mode_q;
		wr_key   = cmd.commit && mode_q && !hit_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q     <= s_tuser[0];
			in_key_q   <= s_tdata[KEY_BITS-1:0];
			in_value_q <= s_tdata[IN_DATA_W-1:KEY_BITS];
		end
		if (cmd.lookup) begin
			hit_q        <= hit_c;
			hit_idx_q    <= hit_idx_c;
			hit_rank_q   <= hit_rank_c;
			victim_idx_q <= victim_idx_c;
			free_idx_q   <= free_idx_c;
			full_q       <= full_c;
		end
		if (wr_key) begin
			key_q[slot] <= in_key_q;
		end
		if (wr_value) begin
			value_q[slot] <= in_value_q;
		end
		if (cmd.commit) begin
			out_found_q <= hit_q;
			out_value_q <= (!mode_q && hit_q) ? value_q[hit_idx_q] : '1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			used_q  <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				rank_q[i] <= '0;
			end
		end else begin
			if (touch) begin
				for (int i = 0; i < CAPACITY; i++) begin
					if (IDX_W'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (insert || (rank_q[i] < thr))) begin
						rank_q[i] <= rank_q[i] + RANK_W'(1);
					end
				end
			end
			if (insert) begin
				valid_q[slot] <= 1'b1;
				used_q        <= used_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cap_q <= cfg_data;
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.out_free = !out_valid_q || m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = out_value_q;
	assign m_tuser[0]      = out_found_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for lru_key_value_cache_unit. A short table of get/put
// transactions and capacity writes covers key and value extremes, limits out
// of range, lowering the limit below occupancy and updates of present keys.
// Random phases follow, each with its own capacity and a small key pool so
// that hits, updates and evictions are frequent. Results are checked against
// the table's replies where given, else a cycle-free LRU predictor in this
// file, under random stalls on both streams outside the two calm phases.
// ----------------------------------------------------------------------------
module tb_top;

	import lkvc_pkg::*;

	typedef enum bit {
		OP_GET = 1'b0,
		OP_PUT = 1'b1
	} op_e;

	typedef enum bit {
		ROW_ITEM = 1'b0,
		ROW_CFG  = 1'b1
	} row_kind_e;

	typedef struct packed {
		bit              found;
		bit [VALUE_BITS-1:0] value;
	} reply_t;

	typedef struct packed {
		row_kind_e           kind;
		bit [CFG_W-1:0]      limit;
		op_e                 op;
		bit [KEY_BITS-1:0]   key;
		bit [VALUE_BITS-1:0] data;
		bit                  typed;
		reply_t              reply;
	} row_t;

	localparam int CLK_HALF      = 6;
	localparam int DRAIN_CYCLES  = 8;
	localparam int LIMIT_CYCLES  = 200000;
	localparam int PHASES        = 15;
	localparam int PHASE_ITEMS   = 77;
	localparam int DIRECTED_ROWS = 25;

	localparam bit [31:0] KMIN = 32'h8000_0000;
	localparam bit [31:0] KMAX = 32'h7FFF_FFFF;
	localparam bit [31:0] ONES = 32'hFFFF_FFFF;
	localparam reply_t    MISS = '{found: 1'b0, value: ONES};
	localparam reply_t    KEPT = '{found: 1'b1, value: ONES};
	localparam reply_t    NONE = '{found: 1'b0, value: 32'h0};

	localparam bit [11:0][CFG_W-1:0] CAP_PLAN = {
		5'd15, 5'd16, 5'd3, 5'd12, 5'd4, 5'd17,
		5'd8, 5'd2, 5'd31, 5'd0, 5'd1, 5'd16
	};

	row_t directed [DIRECTED_ROWS] = '{
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h0,  32'h0,         1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_PUT, KMIN,   KMAX,          1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_PUT, KMAX,   KMIN,          1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_GET, KMIN,   32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_GET, KMAX,   ONES,          1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, KMIN,   ONES,          1'b1, KEPT},
		'{ROW_ITEM, 5'd0,  OP_GET, KMIN,   32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, 32'h0,  32'h0,         1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_PUT, ONES,   32'h1234_5678, 1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h0,  32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h1,  32'h0,         1'b1, MISS},
		'{ROW_CFG,  5'd0,  OP_GET, 32'h0,  32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, 32'h5,  32'h5,         1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_GET, KMAX,   32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h5,  32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, 32'h6,  32'h6,         1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h5,  32'h0,         1'b0, NONE},
		'{ROW_CFG,  5'd31, OP_GET, 32'h0,  32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, 32'h7,  32'h7,         1'b1, MISS},
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h6,  32'h0,         1'b0, NONE},
		'{ROW_CFG,  5'd1,  OP_GET, 32'h0,  32'h0,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, 32'h8,  32'h8,         1'b0, NONE},
		'{ROW_ITEM, 5'd0,  OP_PUT, 32'h8,  32'h9,         1'b1, KEPT},
		'{ROW_ITEM, 5'd0,  OP_GET, 32'h8,  32'h0,         1'b0, NONE},
		'{ROW_CFG,  5'd16, OP_GET, 32'h0,  32'h0,         1'b0, NONE}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [VALUE_BITS-1:0] m_tdata;
	logic [0:0]            m_tuser;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_W-1:0]      cfg_data = '0;

	// shadow of the cache contents and recency order
	bit                  shadow_valid [CAPACITY];
	bit [KEY_BITS-1:0]   shadow_key   [CAPACITY];
	bit [VALUE_BITS-1:0] shadow_value [CAPACITY];
	int                  shadow_rank  [CAPACITY];
	int                  shadow_used = 0;
	bit [CFG_W-1:0]      shadow_limit = CAP_RESET;

	reply_t              pending_replies [$];
	bit [KEY_BITS-1:0]   key_pool [24];
	logic                calm = 1'b0;
	int                  cycles = 0;
	int                  n_errors = 0;
	int                  n_results = 0;
	int                  n_gets = 0;
	int                  n_hits = 0;
	int                  n_puts = 0;
	int                  n_evictions = 0;
	int                  n_settings = 0;

	lru_key_value_cache_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	function automatic void make_newest(input int e);
		int r;
		r = shadow_rank[e];
		for (int i = 0; i < CAPACITY; i++) begin
			if (shadow_valid[i] && i != e && shadow_rank[i] < r)
				shadow_rank[i]++;
		end
		shadow_rank[e] = 0;
	endfunction

	function automatic reply_t cache_access(input op_e op, input bit [KEY_BITS-1:0] key,
			input bit [VALUE_BITS-1:0] data);
		reply_t rsp;
		int     slot;
		int     lim;
		slot = -1;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (shadow_valid[i] && shadow_key[i] == key)
				slot = i;
		end
		rsp.found = (slot >= 0);
		rsp.value = ONES;
		if (op == OP_GET) begin
			n_gets++;
			if (slot >= 0) begin
				n_hits++;
				rsp.value = shadow_value[slot];
				make_newest(slot);
			end
			return rsp;
		end
		n_puts++;
		if (slot >= 0) begin
			shadow_value[slot] = data;
			make_newest(slot);
			return rsp;
		end
		lim = shadow_limit;
		if (lim < 1)
			lim = 1;
		if (lim > CAPACITY)
			lim = CAPACITY;
		if (shadow_used >= lim) begin
			// reuse the slot of the least recent entry
			slot = 0;
			for (int i = 0; i < CAPACITY; i++) begin
				if (shadow_valid[i] && shadow_rank[i] == shadow_used - 1)
					slot = i;
			end
			shadow_key[slot] = key;
			shadow_value[slot] = data;
			make_newest(slot);
			n_evictions++;
			return rsp;
		end
		slot = 0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (!shadow_valid[i])
				slot = i;
		end
		for (int i = 0; i < CAPACITY; i++) begin
			if (shadow_valid[i])
				shadow_rank[i]++;
		end
		shadow_valid[slot] = 1'b1;
		shadow_key[slot] = key;
		shadow_value[slot] = data;
		shadow_rank[slot] = 0;
		shadow_used++;
		return rsp;
	endfunction

	task automatic send_request(input op_e op, input bit [KEY_BITS-1:0] key,
			input bit [VALUE_BITS-1:0] data, input bit typed, input reply_t typed_reply);
		reply_t predicted;
		while (!calm && $urandom_range(0, 99) < 8) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {data, key};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		predicted = cache_access(op, key, data);
		pending_replies.push_back(typed ? typed_reply : predicted);
	endtask

	task automatic write_capacity(input bit [CFG_W-1:0] limit);
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= limit;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shadow_limit = limit;
		n_settings++;
	endtask

	// result check and output back-pressure
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_replies.size() == 0) begin
				$error("unexpected transaction: found %0d value_out %h", m_tuser[0], m_tdata);
				n_errors++;
			end else begin
				want = pending_replies.pop_front();
				if (m_tuser[0] !== want.found) begin
					$error("found mismatch: expected %0d actual %0d", want.found, m_tuser[0]);
					n_errors++;
				end
				if (m_tdata !== want.value) begin
					$error("value_out mismatch: expected %h actual %h", want.value, m_tdata);
					n_errors++;
				end
			end
		end
		m_tready <= calm || ($urandom_range(0, 99) >= 8);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("timeout with %0d results outstanding", pending_replies.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		op_e               op;
		bit [KEY_BITS-1:0] key;
		int                pool_n;
		for (int i = 0; i < CAPACITY; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i] = '0;
			shadow_value[i] = '0;
			shadow_rank[i] = 0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG)
				write_capacity(directed[i].limit);
			else
				send_request(directed[i].op, directed[i].key, directed[i].data,
					directed[i].typed, directed[i].reply);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			write_capacity(phase < 12 ? CAP_PLAN[phase] : CFG_W'($urandom_range(0, 31)));
			calm <= (phase == 4 || phase == 5);
			pool_n = $urandom_range(1, 24);
			for (int i = 0; i < pool_n; i++)
				key_pool[i] = $urandom;
			repeat (PHASE_ITEMS) begin
				op = ($urandom_range(0, 99) < 45) ? OP_PUT : OP_GET;
				if ($urandom_range(0, 9) == 0)
					key = $urandom;
				else
					key = key_pool[$urandom_range(0, pool_n - 1)];
				send_request(op, key, $urandom, 1'b0, NONE);
			end
		end

		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d results checked: %0d gets (%0d hits), %0d puts, %0d evictions",
			n_results, n_gets, n_hits, n_puts, n_evictions);
		$display("capacity written %0d times, including 0, 1, 16, 17 and 31", n_settings);
		if (n_errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
